// ===== sv/byte_ring_buffer_unit_defines.svh =====
// Assertion macros shared by the byte ring buffer RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef BYTE_RING_BUFFER_UNIT_DEFINES_SVH
`define BYTE_RING_BUFFER_UNIT_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define BRB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define BRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/brb_pkg.sv =====
// Package for the byte ring buffer: command codes and item structs.
// No dependencies; used by byte_ring_buffer_unit.
package brb_pkg;

    localparam int SIZE_W   = 11;
    localparam int DATA_W   = 64;
    localparam int MAX_XFER = 8;

    localparam logic [2:0] CMD_WRITE   = 3'd0;
    localparam logic [2:0] CMD_READ    = 3'd1;
    localparam logic [2:0] CMD_PEEK    = 3'd2;
    localparam logic [2:0] CMD_DISCARD = 3'd3;
    localparam logic [2:0] CMD_ADVANCE = 3'd4;
    localparam logic [2:0] CMD_CLEAR   = 3'd5;

    typedef struct packed {
        logic [2:0]        command;
        logic [SIZE_W-1:0] count;
        logic [DATA_W-1:0] write_bytes;
    } t_in;

    typedef struct packed {
        logic [SIZE_W-1:0] done_count;
        logic [DATA_W-1:0] read_bytes;
        logic [SIZE_W-1:0] used_bytes;
        logic [SIZE_W-1:0] free_bytes;
        logic [SIZE_W-1:0] contiguous_read;
        logic [SIZE_W-1:0] contiguous_write;
    } t_out;

endpackage

// ===== sv/brb_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; one instance per byte bank of the ring buffer.
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/byte_ring_buffer_unit.sv =====
// Top level of the byte ring buffer: pointer control, eight byte banks and result stages.
// Depends on brb_pkg, brb_ram and byte_ring_buffer_unit_defines.svh.
//
// Usage: commands arrive on the input channel (i_in_valid / o_in_ready, payload
// i_in_item) and every command yields exactly one result item on the output channel
// (o_out_valid / i_out_ready, payload o_out_item). A command writes, reads, peeks,
// discards, advances the write pointer or clears; a transfer is all or nothing.
// Throughput is one command per cycle unless the output stalls. The pointer decision
// for a command is made in the cycle it is accepted, and the eight byte banks are read
// or written at that same edge, so a command always sees the effect of the one before it.
// After acceptance the command passes the registered bank read, then byte alignment
// and the size calculation, whose result is written into the
// output register. Both pointers are cleared by reset and the input is not ready
// while reset is held; the byte store is not cleared, and reading bytes never
// written is meaningless. When the receiver stalls, the output register holds its
// item and the bank stage behind it holds one more, so the input keeps being
// accepted until both are full.
// DEPTH must be a multiple of eight so that the byte banks wrap with the pointers.
`include "byte_ring_buffer_unit_defines.svh"

module byte_ring_buffer_unit #(
    parameter int DEPTH   = 1024,
    parameter int RESERVE = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  brb_pkg::t_in  i_in_item,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output brb_pkg::t_out o_out_item
);

    import brb_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = (PW + 1 > SIZE_W) ? PW + 1 : SIZE_W;
    localparam int NR = DEPTH / MAX_XFER;
    localparam int RW = PW - 3;

    // Pointer arithmetic helpers in CW bits, and a row increment that wraps at NR.
    function automatic logic [PW-1:0] f_wrap(input logic [PW-1:0] p,
                                             input logic [CW-1:0] n);
        logic [CW-1:0] s;
        s = CW'(p) + n;
        if (s >= CW'(DEPTH)) begin
            s = s - CW'(DEPTH);
        end
        return s[PW-1:0];
    endfunction

    function automatic logic [CW-1:0] f_used(input logic [PW-1:0] rp,
                                             input logic [PW-1:0] wp);
        if (wp >= rp) begin
            return CW'(wp) - CW'(rp);
        end
        return CW'(DEPTH) - CW'(rp) + CW'(wp);
    endfunction

    function automatic logic [CW-1:0] f_free(input logic [CW-1:0] used);
        if (used + CW'(RESERVE) < CW'(DEPTH)) begin
            return CW'(DEPTH) - used - CW'(RESERVE);
        end
        return '0;
    endfunction

    function automatic logic [RW-1:0] f_row_inc(input logic [RW-1:0] row);
        if (row == RW'(NR - 1)) begin
            return '0;
        end
        return row + 1'b1;
    endfunction

    // Pointer state and the handshake of the two result stages.
    logic [PW-1:0] r_rp, r_wp;
    logic [PW-1:0] n_rp, n_wp;
    logic          r_a_valid, r_b_valid;
    logic          a_move, in_accept;

    // Bank stage: what is needed to finish the result once bank data is out.
    logic [SIZE_W-1:0] r_a_done;
    logic [3:0]        r_a_rd_n;
    logic [2:0]        r_a_rot;
    logic [PW-1:0]     r_a_rp, r_a_wp;
    logic [SIZE_W-1:0] n_done;
    logic [3:0]        n_rd_n;

    t_out r_b_item;
    t_out n_b_item;

    logic [CW-1:0] used_c, free_c, cnt_e;
    logic          small_ok, do_write;
    logic [PW-1:0] rp_step, wp_step;

    assign a_move    = r_a_valid && (!r_b_valid || i_out_ready);
    assign o_in_ready = i_rst_n && (!r_a_valid || a_move);
    assign in_accept = i_in_valid && o_in_ready;

    assign used_c   = f_used(r_rp, r_wp);
    assign free_c   = f_free(used_c);
    assign cnt_e    = CW'(i_in_item.count);
    assign small_ok = (i_in_item.count != '0) && (i_in_item.count <= SIZE_W'(MAX_XFER));
    assign rp_step  = f_wrap(r_rp, cnt_e);
    assign wp_step  = f_wrap(r_wp, cnt_e);

    // Command decision: acceptance, next pointers and the byte count returned.
    always_comb begin
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_done   = '0;
        n_rd_n   = '0;
        do_write = 1'b0;
        case (i_in_item.command)
            CMD_WRITE: begin
                if (small_ok && cnt_e <= free_c) begin
                    n_wp     = wp_step;
                    n_done   = i_in_item.count;
                    do_write = 1'b1;
                end
            end
            CMD_READ, CMD_PEEK: begin
                if (small_ok && cnt_e <= used_c) begin
                    n_done = i_in_item.count;
                    n_rd_n = i_in_item.count[3:0];
                    if (i_in_item.command == CMD_READ) begin
                        // A read that drains the buffer rewinds both pointers.
                        if (rp_step == r_wp) begin
                            n_rp = '0;
                            n_wp = '0;
                        end else begin
                            n_rp = rp_step;
                        end
                    end
                end
            end
            CMD_DISCARD: begin
                if (i_in_item.count != '0 && cnt_e <= used_c) begin
                    n_rp   = rp_step;
                    n_done = i_in_item.count;
                end
            end
            CMD_ADVANCE: begin
                if (i_in_item.count != '0 && cnt_e <= free_c) begin
                    n_wp   = wp_step;
                    n_done = i_in_item.count;
                end
            end
            CMD_CLEAR: begin
                n_rp = '0;
                n_wp = '0;
            end
            default: begin
            end
        endcase
    end

    // Eight byte banks: address a lives in bank a mod 8, row a / 8. A transfer of up
    // to eight bytes touches each bank at most once, even across the wrap.
    logic [7:0]    wbyte  [MAX_XFER];
    logic [7:0]    bank_q [MAX_XFER];
    logic [RW-1:0] wrow_base, wrow_next, rrow_base, rrow_next;

    assign wrow_base = r_wp[PW-1:3];
    assign wrow_next = f_row_inc(wrow_base);
    assign rrow_base = r_rp[PW-1:3];
    assign rrow_next = f_row_inc(rrow_base);

    for (genvar k = 0; k < MAX_XFER; k++) begin : g_bank
        logic [2:0]    wofs;
        logic          bank_we;
        logic [RW-1:0] waddr, raddr;

        assign wbyte[k] = i_in_item.write_bytes[8*k +: 8];
        assign wofs     = 3'(k) - r_wp[2:0];
        assign bank_we  = in_accept && do_write && (4'(wofs) < i_in_item.count[3:0]);
        assign waddr    = (3'(k) < r_wp[2:0]) ? wrow_next : wrow_base;
        assign raddr    = (3'(k) < r_rp[2:0]) ? rrow_next : rrow_base;

        brb_ram #(
            .WIDTH(8),
            .DEPTH(NR)
        ) u_bank (
            .i_clk  (i_clk),
            .i_we   (bank_we),
            .i_waddr(waddr),
            .i_wdata(wbyte[wofs]),
            .i_re   (in_accept),
            .i_raddr(raddr),
            .o_rdata(bank_q[k])
        );
    end

    // Result assembly: rotate the bank outputs so the oldest byte sits lowest,
    // zero the bytes beyond the count, and work out the sizes from the new pointers.
    logic [CW-1:0] used_a, cr_a, cw_a, diff_a, wrap_a;

    assign used_a = f_used(r_a_rp, r_a_wp);
    assign diff_a = CW'(r_a_rp) - CW'(r_a_wp);
    assign wrap_a = CW'(DEPTH) - CW'(r_a_wp) + CW'(r_a_rp);

    always_comb begin
        if (r_a_rp <= r_a_wp) begin
            cr_a = CW'(r_a_wp) - CW'(r_a_rp);
        end else begin
            cr_a = CW'(DEPTH) - CW'(r_a_rp);
        end
        if (r_a_wp < r_a_rp) begin
            cw_a = (diff_a > CW'(RESERVE)) ? diff_a - CW'(RESERVE) : '0;
        end else if (CW'(r_a_rp) < CW'(RESERVE)) begin
            cw_a = (wrap_a > CW'(RESERVE)) ? wrap_a - CW'(RESERVE) : '0;
        end else begin
            cw_a = CW'(DEPTH) - CW'(r_a_wp);
        end
    end

    always_comb begin
        n_b_item.done_count       = r_a_done;
        n_b_item.used_bytes       = SIZE_W'(used_a);
        n_b_item.free_bytes       = SIZE_W'(f_free(used_a));
        n_b_item.contiguous_read  = SIZE_W'(cr_a);
        n_b_item.contiguous_write = SIZE_W'(cw_a);
        for (int k = 0; k < MAX_XFER; k++) begin
            n_b_item.read_bytes[8*k +: 8] =
                (4'(k) < r_a_rd_n) ? bank_q[3'(r_a_rot + 3'(k))] : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp      <= '0;
            r_wp      <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_rp <= n_rp;
                r_wp <= n_wp;
            end
            if (in_accept) begin
                r_a_valid <= 1'b1;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end
            if (a_move) begin
                r_b_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_done <= n_done;
            r_a_rd_n <= n_rd_n;
            r_a_rot  <= r_rp[2:0];
            r_a_rp   <= n_rp;
            r_a_wp   <= n_wp;
        end
        if (a_move) begin
            r_b_item <= n_b_item;
        end
    end

    assign o_out_valid = r_b_valid;
    assign o_out_item  = r_b_item;

    // The reserve is never given away, so the fill level stays bounded.
    `BRB_ASSERT_NOW(a_used_bound, i_clk, i_rst_n, 1'b1,
        used_c <= CW'(DEPTH - RESERVE), "fill level exceeds DEPTH - RESERVE")
    // Used and free sizes of every result always add up to the usable capacity.
    `BRB_ASSERT_NOW(a_size_sum, i_clk, i_rst_n, o_out_valid,
        SIZE_W'(o_out_item.used_bytes + o_out_item.free_bytes + SIZE_W'(RESERVE))
            == SIZE_W'(DEPTH), "used and free sizes disagree")
    // A result with a zero byte count (a rejected command or a clear) returns no bytes.
    `BRB_ASSERT_NOW(a_reject_zero, i_clk, i_rst_n,
        o_out_valid && o_out_item.done_count == '0,
        o_out_item.read_bytes == '0, "read bytes set on a rejected command")
    // An accepted command always lands in the bank stage.
    `BRB_ASSERT_NEXT(a_accept_stage, i_clk, i_rst_n, in_accept,
        r_a_valid, "accepted command lost before the bank stage")

endmodule

// ===== tb/sv/byte_ring_buffer_checker.sv =====
// Scoreboard for the byte ring buffer: follows both item channels, predicts every result
// from its own copy of the pointers and byte store, and compares field by field.
// Depends on brb_pkg only.
module byte_ring_buffer_checker
    import brb_pkg::*;
#(
    parameter int DEPTH   = 1024,
    parameter int RESERVE = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_item,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_item,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW = $clog2(DEPTH);

    logic [7:0]  ring_bytes [DEPTH];
    int unsigned head_ptr = 0;
    int unsigned tail_ptr = 0;
    t_out        expected_results [$];
    t_out        want;
    int          fail_total   = 0;
    int          result_index = 0;

    function automatic int unsigned held_count();
        return (tail_ptr >= head_ptr) ? tail_ptr - head_ptr : DEPTH - head_ptr + tail_ptr;
    endfunction

    function automatic int unsigned space_count();
        return (DEPTH > held_count() + RESERVE) ? DEPTH - held_count() - RESERVE : 0;
    endfunction

    function automatic int unsigned read_run();
        return (head_ptr <= tail_ptr) ? tail_ptr - head_ptr : DEPTH - head_ptr;
    endfunction

    // Writable span from the tail; the reserve is charged whenever the
    // span would run up to the head.
    function automatic int unsigned write_run();
        int unsigned span;
        if (tail_ptr < head_ptr) begin
            span = head_ptr - tail_ptr;
            return (span > RESERVE) ? span - RESERVE : 0;
        end
        if (head_ptr < RESERVE) begin
            span = DEPTH - tail_ptr + head_ptr;
            return (span > RESERVE) ? span - RESERVE : 0;
        end
        return DEPTH - tail_ptr;
    endfunction

    // Runs one command against the local state and returns the result it should give.
    function automatic t_out apply_command(input t_in cmd_item);
        t_out        res;
        int unsigned n;
        int unsigned held;
        int unsigned room;
        res  = '0;
        n    = 32'(cmd_item.count);
        held = held_count();
        room = space_count();
        case (cmd_item.command)
            CMD_WRITE: begin
                if (n >= 1 && n <= MAX_XFER && n <= room) begin
                    for (int k = 0; k < n; k++)
                        ring_bytes[AW'((tail_ptr + k) % DEPTH)] =
                            cmd_item.write_bytes[8*k +: 8];
                    tail_ptr = (tail_ptr + n) % DEPTH;
                    res.done_count = SIZE_W'(n);
                end
            end
            CMD_READ, CMD_PEEK: begin
                if (n >= 1 && n <= MAX_XFER && n <= held) begin
                    for (int k = 0; k < n; k++)
                        res.read_bytes[8*k +: 8] = ring_bytes[AW'((head_ptr + k) % DEPTH)];
                    res.done_count = SIZE_W'(n);
                    if (cmd_item.command == CMD_READ) begin
                        head_ptr = (head_ptr + n) % DEPTH;
                        // A read that drains the buffer rewinds both pointers.
                        if (head_ptr == tail_ptr) begin
                            head_ptr = 0;
                            tail_ptr = 0;
                        end
                    end
                end
            end
            CMD_DISCARD: begin
                if (n >= 1 && n <= held) begin
                    head_ptr = (head_ptr + n) % DEPTH;
                    res.done_count = SIZE_W'(n);
                end
            end
            CMD_ADVANCE: begin
                if (n >= 1 && n <= room) begin
                    tail_ptr = (tail_ptr + n) % DEPTH;
                    res.done_count = SIZE_W'(n);
                end
            end
            CMD_CLEAR: begin
                head_ptr = 0;
                tail_ptr = 0;
            end
            default: ;
        endcase
        res.used_bytes       = SIZE_W'(held_count());
        res.free_bytes       = SIZE_W'(space_count());
        res.contiguous_read  = SIZE_W'(read_run());
        res.contiguous_write = SIZE_W'(write_run());
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [63:0] exp_val,
                                 input logic [63:0] act_val);
        if (exp_val !== act_val) begin
            fail_total++;
            if (fail_total <= 10)
                $display("%0t ns: result %0d, %s expected 0x%0h, got 0x%0h",
                         $time, result_index, field, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                expected_results.push_back(apply_command(i_in_item));
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t ns: result %0d arrived with nothing outstanding",
                                 $time, result_index);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("done_count", 64'(want.done_count),
                                  64'(i_out_item.done_count));
                    compare_field("read_bytes", want.read_bytes, i_out_item.read_bytes);
                    compare_field("used_bytes", 64'(want.used_bytes),
                                  64'(i_out_item.used_bytes));
                    compare_field("free_bytes", 64'(want.free_bytes),
                                  64'(i_out_item.free_bytes));
                    compare_field("contiguous_read", 64'(want.contiguous_read),
                                  64'(i_out_item.contiguous_read));
                    compare_field("contiguous_write", 64'(want.contiguous_write),
                                  64'(i_out_item.contiguous_write));
                end
                result_index++;
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== tb/sv/byte_ring_buffer_unit_tb.sv =====
// Top of the byte ring buffer testbench: clock, reset, command stimulus and the verdict.
// Depends on brb_pkg, byte_ring_buffer_unit and byte_ring_buffer_checker.
module byte_ring_buffer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brb_pkg::*;

    localparam int BUF_DEPTH   = 1024;
    localparam int BUF_RESERVE = 8;
    localparam int BUF_AW      = $clog2(BUF_DEPTH);
    localparam int ITEM_TARGET = 1850;

    // The package names six commands; the two remaining codes must be ignored.
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_in  in_item   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_item;
    int   fail_count;
    int   pending;

    // Light copy of the pointers, kept only so that the stimulus can aim its counts
    // at the current fill level and never read a byte that was never written.
    int unsigned sh_rd = 0;
    int unsigned sh_wr = 0;
    bit          written [BUF_DEPTH];

    // Sender and receiver idling: mode 0 never idles, 1 idles a little, 2 a lot.
    int          tx_mode       = 1;
    int          rx_mode       = 0;
    int unsigned rx_mode_left  = 0;
    int unsigned rx_stall_left = 0;

    int items_sent = 0;
    int sent_by_cmd [8];
    int refused    = 0;
    int full_hits  = 0;
    int wraps      = 0;

    always #4 clk = ~clk;

    byte_ring_buffer_unit #(
        .DEPTH  (BUF_DEPTH),
        .RESERVE(BUF_RESERVE)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    byte_ring_buffer_checker #(
        .DEPTH  (BUF_DEPTH),
        .RESERVE(BUF_RESERVE)
    ) ring_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Mostly no gap or a short one, now and then a long one.
    function automatic int unsigned pick_gap(input int mode);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case (mode)
            0: return 0;
            1: begin
                if (roll < 70) return 0;
                if (roll < 97) return $urandom_range(1, 3);
                return $urandom_range(8, 40);
            end
            default: begin
                if (roll < 35) return 0;
                if (roll < 90) return $urandom_range(1, 4);
                return $urandom_range(8, 40);
            end
        endcase
    endfunction

    function automatic int unsigned shadow_used();
        return (sh_wr + BUF_DEPTH - sh_rd) % BUF_DEPTH;
    endfunction

    function automatic int unsigned shadow_room();
        return BUF_DEPTH - BUF_RESERVE - shadow_used();
    endfunction

    // Number of bytes at the head of the buffer that have been written at some point,
    // capped at one transfer. Reads and peeks that can be accepted never ask for more than this.
    function automatic int unsigned readable_run();
        int unsigned lim;
        int unsigned k;
        lim = (shadow_used() < MAX_XFER) ? shadow_used() : MAX_XFER;
        k   = 0;
        while (k < lim && written[BUF_AW'((sh_rd + k) % BUF_DEPTH)])
            k++;
        return k;
    endfunction

    // Moves the stimulus copy of the pointers along as the command will move the
    // block's, and keeps the tallies for the closing summary.
    function automatic void track(input t_in cmd_item);
        int unsigned n;
        int unsigned used;
        int unsigned room;
        bit          ok;
        n    = 32'(cmd_item.count);
        used = shadow_used();
        room = shadow_room();
        ok   = 1'b0;
        sent_by_cmd[cmd_item.command]++;
        case (cmd_item.command)
            CMD_WRITE: begin
                ok = (n >= 1 && n <= MAX_XFER && n <= room);
                if (ok) begin
                    for (int k = 0; k < n; k++)
                        written[BUF_AW'((sh_wr + k) % BUF_DEPTH)] = 1'b1;
                    if (sh_wr + n >= BUF_DEPTH) wraps++;
                    sh_wr = (sh_wr + n) % BUF_DEPTH;
                end
            end
            CMD_READ, CMD_PEEK: begin
                ok = (n >= 1 && n <= MAX_XFER && n <= used);
                if (ok && cmd_item.command == CMD_READ) begin
                    sh_rd = (sh_rd + n) % BUF_DEPTH;
                    if (sh_rd == sh_wr) begin
                        sh_rd = 0;
                        sh_wr = 0;
                    end
                end
            end
            CMD_DISCARD: begin
                ok = (n >= 1 && n <= used);
                if (ok) sh_rd = (sh_rd + n) % BUF_DEPTH;
            end
            CMD_ADVANCE: begin
                ok = (n >= 1 && n <= room);
                if (ok) begin
                    if (sh_wr + n >= BUF_DEPTH) wraps++;
                    sh_wr = (sh_wr + n) % BUF_DEPTH;
                end
            end
            CMD_CLEAR: begin
                ok    = 1'b1;
                sh_rd = 0;
                sh_wr = 0;
            end
            default: ;
        endcase
        if (!ok) refused++;
        if (ok && shadow_room() == 0) full_hits++;
    endfunction

    // Presents one item, after an optional idle gap, and returns at the edge that
    // accepts it. Valid stays high across back-to-back items.
    task automatic send_item(input t_in cmd_item);
        int unsigned gap;
        gap = pick_gap(tx_mode);
        track(cmd_item);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_item  <= cmd_item;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic issue(input logic [2:0] op, input int unsigned n, input logic [63:0] data);
        t_in cmd_item;
        cmd_item.command     = op;
        cmd_item.count       = SIZE_W'(n);
        cmd_item.write_bytes = data;
        send_item(cmd_item);
    endtask

    // Holds the sender off until the checker has nothing outstanding.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // A random command aimed at the present fill level. Fill phases favour writes
    // and advances so that the buffer runs up to its limit; drain phases favour
    // reads and discards so that it empties and the pointers rewind. A small share
    // is noise: any code, any count, mostly refused.
    function automatic t_in random_item(input bit fill);
        t_in         cmd_item;
        int unsigned used;
        int unsigned room;
        int unsigned run;
        int unsigned roll;
        used = shadow_used();
        room = shadow_room();
        run  = readable_run();
        roll = $urandom_range(0, 99);
        cmd_item.write_bytes = {$urandom, $urandom};
        cmd_item.command     = CMD_CLEAR;
        cmd_item.count       = SIZE_W'($urandom_range(0, 3));
        if (roll < 6) begin
            cmd_item.command = 3'($urandom_range(0, 7));
            cmd_item.count   = SIZE_W'($urandom_range(0, 2047));
            // Never let noise read a byte that was never written.
            if ((cmd_item.command == CMD_READ || cmd_item.command == CMD_PEEK) &&
                cmd_item.count >= 1 && cmd_item.count <= MAX_XFER &&
                cmd_item.count <= used && cmd_item.count > run)
                cmd_item.count = '0;
        end else if (roll < (fill ? 61 : 34)) begin
            cmd_item.command = CMD_WRITE;
            if (room == 0)
                cmd_item.count = SIZE_W'($urandom_range(1, MAX_XFER));
            else
                cmd_item.count =
                    SIZE_W'($urandom_range(1, (room < MAX_XFER) ? room : MAX_XFER));
        end else if (roll < 80) begin
            cmd_item.command = ($urandom_range(0, 3) == 0) ? CMD_PEEK : CMD_READ;
            if (run != 0) begin
                cmd_item.count = SIZE_W'($urandom_range(1, run));
            end else if (used != 0) begin
                // The head holds bytes skipped by an advance: throw them away instead.
                cmd_item.command = CMD_DISCARD;
                cmd_item.count   = SIZE_W'(used);
            end else begin
                cmd_item.count = SIZE_W'($urandom_range(1, MAX_XFER));
            end
        end else if (roll < (fill ? 86 : 92)) begin
            cmd_item.command = CMD_DISCARD;
            if (used == 0)
                cmd_item.count = SIZE_W'($urandom_range(1, 4));
            else if ($urandom_range(0, 9) == 0)
                cmd_item.count = SIZE_W'(used + 1);
            else if ($urandom_range(0, 3) == 0)
                cmd_item.count = SIZE_W'($urandom_range(1, used));
            else
                cmd_item.count = SIZE_W'($urandom_range(1, (used < 16) ? used : 16));
        end else if (roll < 98) begin
            cmd_item.command = CMD_ADVANCE;
            if (room == 0)
                cmd_item.count = SIZE_W'($urandom_range(1, MAX_XFER));
            else if ($urandom_range(0, 5) == 0)
                cmd_item.count = SIZE_W'($urandom_range(1, room));
            else
                cmd_item.count = SIZE_W'($urandom_range(1, (room < 24) ? room : 24));
        end
        return cmd_item;
    endfunction

    // The receiver picks a new mood whenever its mood countdown runs out, so that there are long
    // stretches of full throughput as well as stretches of heavy back-pressure.
    always @(posedge clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(50, 400);
        end else begin
            rx_mode_left--;
        end
        if (rx_stall_left != 0) begin
            rx_stall_left--;
            out_ready <= 1'b0;
        end else begin
            rx_stall_left = pick_gap(rx_mode);
            if (rx_stall_left == 0) begin
                out_ready <= 1'b1;
            end else begin
                rx_stall_left--;
                out_ready <= 1'b0;
            end
        end
    end

    initial begin
        #(5_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int phase_idx;
        int plen;
        bit fill;
        phase_idx = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening. An empty buffer refuses every read, peek and discard.
        tx_mode = 1;
        issue(CMD_READ, 1, 64'h0);
        issue(CMD_PEEK, 1, 64'h0);
        issue(CMD_DISCARD, 1, 64'h0);
        issue(CMD_WRITE, 0, '1);
        issue(CMD_WRITE, 8, '1);
        // Nine bytes is more than one transfer may carry.
        issue(CMD_WRITE, 9, 64'h0123_4567_89ab_cdef);
        issue(CMD_PEEK, 8, 64'h0);
        issue(CMD_READ, 0, 64'h0);
        issue(CMD_READ, 9, 64'h0);
        // Reading the last bytes out sends both pointers back to zero.
        issue(CMD_READ, 8, 64'h0);
        issue(CMD_WRITE, 8, 64'h0);
        issue(CMD_WRITE, 3, 64'hdead_beef_00a5_5a3c);
        issue(CMD_DISCARD, 2, 64'h0);
        issue(CMD_ADVANCE, 0, 64'h0);
        issue(CMD_ADVANCE, BUF_DEPTH, 64'h0);
        issue(CMD_ADVANCE, shadow_room() + 1, 64'h0);
        // Advance to exactly full, then check that a single byte no longer fits.
        issue(CMD_ADVANCE, shadow_room(), 64'h0);
        issue(CMD_WRITE, 1, 64'h77);
        issue(CMD_DISCARD, shadow_used() + 1, 64'h0);
        // Discarding everything empties the buffer but leaves the pointers where they are,
        // six bytes short of the end, so the next write and read wrap.
        issue(CMD_DISCARD, shadow_used(), 64'h0);
        issue(CMD_WRITE, 8, 64'hfedc_ba98_7654_3210);
        issue(CMD_PEEK, 8, 64'h0);
        issue(CMD_READ, 5, 64'h0);
        issue(CMD_READ, 3, 64'h0);
        issue(CMD_SPARE_6, 5, '1);
        issue(CMD_SPARE_7, 2047, '1);
        issue(CMD_WRITE, 4, 64'h0bad_cafe_1234_5678);
        issue(CMD_CLEAR, 0, 64'h0);

        // Random phases, each with its own bias and sender mood. The third phase
        // always ends with the sender waiting for every result; others do so at random.
        while (items_sent < ITEM_TARGET) begin
            plen    = $urandom_range(60, 180);
            fill    = (phase_idx % 2 == 0);
            tx_mode = $urandom_range(0, 2);
            for (int i = 0; i < plen && items_sent < ITEM_TARGET; i++)
                send_item(random_item(fill));
            if (phase_idx == 2 || $urandom_range(0, 2) == 0)
                drain_results();
            phase_idx++;
        end

        drain_results();
        repeat (8) @(posedge clk);

        $write("Sent %0d commands: %0d write, %0d read, %0d peek, ",
               items_sent, sent_by_cmd[CMD_WRITE], sent_by_cmd[CMD_READ],
               sent_by_cmd[CMD_PEEK]);
        $display("%0d discard, %0d advance, %0d clear, %0d unknown.",
                 sent_by_cmd[CMD_DISCARD], sent_by_cmd[CMD_ADVANCE],
                 sent_by_cmd[CMD_CLEAR], sent_by_cmd[CMD_SPARE_6] + sent_by_cmd[CMD_SPARE_7]);
        $write("%0d were refused or ignored; the buffer reached full %0d times ",
               refused, full_hits);
        $display("and the write pointer wrapped %0d times.", wraps);
        if (fail_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
